### design/rpn_pkg.sv
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] FN_PUSH  = 4'd0;
    localparam logic [3:0] FN_ADD   = 4'd1;
    localparam logic [3:0] FN_SUB   = 4'd2;
    localparam logic [3:0] FN_MUL   = 4'd3;
    localparam logic [3:0] FN_DIV   = 4'd4;
    localparam logic [3:0] FN_MOD   = 4'd5;
    localparam logic [3:0] FN_DUP   = 4'd6;
    localparam logic [3:0] FN_DROP  = 4'd7;
    localparam logic [3:0] FN_SWAP  = 4'd8;
    localparam logic [3:0] FN_CLEAR = 4'd9;
    localparam logic [3:0] FN_NOP   = 4'd15;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    localparam logic [1:0] AR_MUL = 2'd0;
    localparam logic [1:0] AR_DIV = 2'd1;
    localparam logic [1:0] AR_MOD = 2'd2;

    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [3:0]               func;
        logic signed [DATA_W-1:0] push_value;
    } rpn_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         depth;
        logic signed [DATA_W-1:0] top_value;
    } rpn_out_t;

    // Decoded command as it sits in the queue
    typedef struct packed {
        logic [3:0]        func;
        logic              need_two;
        logic              need_one;
        logic              grows;
        logic              div_like;
        logic [DATA_W-1:0] value;
    } rpn_cmd_t;

endpackage

### design/rpn_ram.sv
module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/rpn_front.sv
module rpn_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpn_pkg::rpn_in_t  s_payload,
    output logic              q_valid,
    input  logic              q_ready,
    output rpn_pkg::rpn_cmd_t q_cmd
);
    import rpn_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rpn_cmd_t cmd_reg;
    rpn_cmd_t cmd_next;
    rpn_cmd_t dec;

    always_comb begin
        dec          = '0;
        dec.func     = s_payload.func;
        dec.value    = s_payload.push_value;
        unique case (s_payload.func)
            FN_PUSH: dec.grows = 1'b1;
            FN_ADD, FN_SUB, FN_MUL: dec.need_two = 1'b1;
            FN_DIV, FN_MOD: begin
                dec.need_two = 1'b1;
                dec.div_like = 1'b1;
            end
            FN_DUP: begin
                dec.need_one = 1'b1;
                dec.grows    = 1'b1;
            end
            FN_DROP:  dec.need_one = 1'b1;
            FN_SWAP:  dec.need_two = 1'b1;
            FN_CLEAR: ;
            default:  dec.func = FN_NOP;
        endcase
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_cmd   = cmd_reg;

    always_comb begin
        valid_next = valid_reg && !q_ready;
        cmd_next   = cmd_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            cmd_next   = dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end
endmodule

### design/rpn_queue.sv
module rpn_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpn_pkg::rpn_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output rpn_pkg::rpn_cmd_t out_cmd
);
    import rpn_pkg::*;

    localparam logic [QPTR_W:0] FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    rpn_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              push;
    logic              pop;

    assign in_ready  = fill_reg != FULL;
    assign out_valid = fill_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

### design/rpn_arith.sv
module rpn_arith (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [1:0]                 op,
    input  logic [rpn_pkg::DATA_W-1:0] a,
    input  logic [rpn_pkg::DATA_W-1:0] b,
    output logic                       done,
    output logic [rpn_pkg::DATA_W-1:0] result
);
    import rpn_pkg::*;

    localparam int HALF = DATA_W / 2;
    localparam int CW   = $clog2(DATA_W + 2);
    localparam logic [CW-1:0] MUL_LAST = CW'(5);
    localparam logic [CW-1:0] DIV_LAST = CW'(DATA_W + 1);

    function automatic logic [DATA_W-1:0] sat_q(input logic neg, input logic big,
                                                input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] r;
        if (neg) begin
            r = (big || (mag > Q_MIN)) ? Q_MIN : (~mag + 1'b1);
        end else begin
            r = (big || mag[DATA_W-1]) ? Q_MAX : mag;
        end
        return r;
    endfunction

    logic                busy_reg;
    logic [1:0]          op_reg;
    logic                neg_reg;
    logic                a_neg_reg;
    logic                big_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DATA_W-1:0]   x_reg;
    logic [DATA_W-1:0]   y_reg;
    logic [2*DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0]   pp_reg;
    logic [1:0]          pp_sh_reg;
    logic                pp_v_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   dvd_reg;
    logic [DATA_W-1:0]   q_reg;
    logic                done_reg;
    logic [DATA_W-1:0]   res_reg;

    logic [HALF-1:0]     xs;
    logic [HALF-1:0]     ys;
    logic [2*DATA_W-1:0] pp_shifted;
    logic [DATA_W:0]     trial;
    logic                fits;
    logic [DATA_W-1:0]   mod_res;

    assign done   = done_reg;
    assign result = res_reg;

    always_comb begin
        xs = cnt_reg[1] ? x_reg[DATA_W-1:HALF] : x_reg[HALF-1:0];
        ys = cnt_reg[0] ? y_reg[DATA_W-1:HALF] : y_reg[HALF-1:0];
        unique case (pp_sh_reg)
            2'd0:    pp_shifted = {{DATA_W{1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HALF{1'b0}}, pp_reg, {HALF{1'b0}}};
            default: pp_shifted = {pp_reg, {DATA_W{1'b0}}};
        endcase
        trial   = {rem_reg, dvd_reg[DATA_W-1]};
        fits    = trial >= {1'b0, y_reg};
        mod_res = a_neg_reg ? (~rem_reg + 1'b1) : rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                op_reg    <= op;
                cnt_reg   <= '0;
                a_neg_reg <= a[DATA_W-1];
                neg_reg   <= a[DATA_W-1] ^ b[DATA_W-1];
                x_reg     <= a[DATA_W-1] ? (~a + 1'b1) : a;
                y_reg     <= b[DATA_W-1] ? (~b + 1'b1) : b;
                acc_reg   <= '0;
                pp_v_reg  <= 1'b0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (op_reg == AR_MUL) begin
                    // four partial products, each registered in pp_reg and accumulated in the following cycle
                    if (cnt_reg < CW'(4)) begin
                        pp_reg    <= xs * ys;
                        pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                        pp_v_reg  <= 1'b1;
                    end else begin
                        pp_v_reg <= 1'b0;
                    end
                    if (pp_v_reg) begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    if (cnt_reg == MUL_LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        res_reg  <= sat_q(neg_reg, |acc_reg[2*DATA_W-1:DATA_W+HALF],
                                          acc_reg[DATA_W+HALF-1:HALF]);
                    end
                end else if (cnt_reg == '0) begin
                    // divide shifts in the low half and HALF zeros, the upper half starting as the
                    // partial remainder; remainder starts from zero and shifts in all of x
                    q_reg <= '0;
                    if (op_reg == AR_DIV) begin
                        rem_reg <= {{HALF{1'b0}}, x_reg[DATA_W-1:HALF]};
                        dvd_reg <= {x_reg[HALF-1:0], {HALF{1'b0}}};
                        big_reg <= {{HALF{1'b0}}, x_reg[DATA_W-1:HALF]} >= y_reg;
                    end else begin
                        rem_reg <= '0;
                        dvd_reg <= x_reg;
                        big_reg <= 1'b0;
                    end
                end else if (cnt_reg != DIV_LAST) begin
                    rem_reg <= fits ? DATA_W'(trial - {1'b0, y_reg}) : trial[DATA_W-1:0];
                    dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
                    q_reg   <= {q_reg[DATA_W-2:0], fits};
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= (op_reg == AR_DIV) ? sat_q(neg_reg, big_reg, q_reg)
                                                   : mod_res;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("arith done without a running operation");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("arith started while busy");
    a_busy_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg)
        else $error("arith stopped without a result");
`endif
endmodule

### design/rpn_back.sv
module rpn_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  rpn_pkg::rpn_cmd_t q_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output rpn_pkg::rpn_out_t m_payload
);
    import rpn_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DEC   = 2'd1;
    localparam logic [1:0] S_ARITH = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] x,
                                                  input logic [DATA_W-1:0] y,
                                                  input logic sub);
        logic [DATA_W-1:0] yy;
        logic [DATA_W-1:0] r;
        yy = sub ? ~y : y;
        r  = x + yy + DATA_W'(sub);
        if ((x[DATA_W-1] == yy[DATA_W-1]) && (r[DATA_W-1] != x[DATA_W-1])) begin
            r = x[DATA_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    logic [1:0]        state_reg,  state_next;
    rpn_cmd_t          cmd_reg,    cmd_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [DATA_W-1:0] top_reg,    top_next;
    logic              m_valid_reg, m_valid_next;
    rpn_out_t          m_data_reg, m_data_next;
    logic [1:0]        fin_status_reg, fin_status_next;
    logic              fin_we_reg,     fin_we_next;
    logic [ADDR_W-1:0] fin_addr_reg,   fin_addr_next;
    logic [DATA_W-1:0] fin_data_reg,   fin_data_next;
    logic [CNT_W-1:0]  fin_cnt_reg,    fin_cnt_next;
    logic [DATA_W-1:0] fin_top_reg,    fin_top_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              ar_start;
    logic [1:0]        ar_op;
    logic              ar_done;
    logic [DATA_W-1:0] ar_result;
    logic              under;
    logic              over;
    logic              commit;

    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_m2    = count_reg - 2'd2;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    rpn_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ar_start),
        .op      (ar_op),
        .a       (ram_rdata),
        .b       (top_reg),
        .done    (ar_done),
        .result  (ar_result)
    );

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        fin_status_next = fin_status_reg;
        fin_we_next     = fin_we_reg;
        fin_addr_next   = fin_addr_reg;
        fin_data_next   = fin_data_reg;
        fin_cnt_next    = fin_cnt_reg;
        fin_top_next    = fin_top_reg;
        ram_we          = 1'b0;
        ram_waddr       = fin_addr_reg;
        ram_wdata       = fin_data_reg;
        ar_start        = 1'b0;
        ar_op           = AR_MUL;
        q_ready         = 1'b0;
        commit          = 1'b0;
        under = (cmd_reg.need_two && (count_reg < CNT_W'(2)))
             || (cmd_reg.need_one && (count_reg == '0));
        over  = cmd_reg.grows && (count_reg == FULL);

        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cmd_next   = q_cmd;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                // stack read of the second entry has landed
                fin_status_next = ST_OK;
                fin_we_next     = 1'b0;
                fin_cnt_next    = count_reg;
                fin_top_next    = top_reg;
                fin_addr_next   = cnt_m2[ADDR_W-1:0];
                state_next      = S_FIN;
                priority if (under) begin
                    fin_status_next = ST_UNDER;
                end else if (over) begin
                    fin_status_next = ST_OVER;
                end else if (cmd_reg.div_like && (top_reg == '0)) begin
                    fin_status_next = ST_DIV0;
                end else begin
                    unique case (cmd_reg.func)
                        FN_PUSH: begin
                            fin_we_next   = 1'b1;
                            fin_addr_next = count_reg[ADDR_W-1:0];
                            fin_data_next = cmd_reg.value;
                            fin_top_next  = cmd_reg.value;
                            fin_cnt_next  = count_reg + 1'b1;
                        end
                        FN_ADD, FN_SUB: begin
                            fin_we_next   = 1'b1;
                            fin_data_next = add_sat(ram_rdata, top_reg,
                                                    cmd_reg.func == FN_SUB);
                            fin_top_next  = fin_data_next;
                            fin_cnt_next  = cnt_m1;
                        end
                        FN_MUL, FN_DIV, FN_MOD: begin
                            ar_start   = 1'b1;
                            ar_op      = (cmd_reg.func == FN_MUL) ? AR_MUL :
                                         (cmd_reg.func == FN_DIV) ? AR_DIV : AR_MOD;
                            state_next = S_ARITH;
                        end
                        FN_DUP: begin
                            fin_we_next   = 1'b1;
                            fin_addr_next = count_reg[ADDR_W-1:0];
                            fin_data_next = top_reg;
                            fin_cnt_next  = count_reg + 1'b1;
                        end
                        FN_DROP: begin
                            fin_top_next = ram_rdata;
                            fin_cnt_next = cnt_m1;
                        end
                        FN_SWAP: begin
                            // write the old second entry on top now, old top below at commit
                            ram_we        = 1'b1;
                            ram_waddr     = cnt_m1[ADDR_W-1:0];
                            ram_wdata     = ram_rdata;
                            fin_we_next   = 1'b1;
                            fin_data_next = top_reg;
                            fin_top_next  = ram_rdata;
                        end
                        FN_CLEAR: fin_cnt_next = '0;
                        default: ;
                    endcase
                end
            end
            S_ARITH: begin
                if (ar_done) begin
                    fin_we_next   = 1'b1;
                    fin_data_next = ar_result;
                    fin_top_next  = ar_result;
                    fin_cnt_next  = cnt_m1;
                    state_next    = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    commit                = 1'b1;
                    ram_we                = fin_we_reg;
                    count_next            = fin_cnt_reg;
                    top_next              = fin_top_reg;
                    m_valid_next          = 1'b1;
                    m_data_next.status    = fin_status_reg;
                    m_data_next.depth     = fin_cnt_reg;
                    m_data_next.top_value = (fin_cnt_reg == '0) ? '0 : fin_top_reg;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        top_reg        <= top_next;
        m_data_reg     <= m_data_next;
        fin_status_reg <= fin_status_next;
        fin_we_reg     <= fin_we_next;
        fin_addr_reg   <= fin_addr_next;
        fin_data_reg   <= fin_data_next;
        fin_cnt_reg    <= fin_cnt_next;
        fin_top_reg    <= fin_top_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("stack count beyond depth");
    a_error_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (fin_status_reg != ST_OK)) |=> (count_reg == $past(count_reg)))
        else $error("failed operation changed the stack depth");
    a_arith_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ar_done |-> (state_reg == S_ARITH))
        else $error("arith result outside wait state");
    a_result_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_valid_reg && (m_data_reg.depth == count_reg)))
        else $error("result depth differs from stack count");
`endif
endmodule

### design/rpn_stack_calculator_core.sv
// Channel   Ports                           Direction  Payload
// input     s_valid / s_ready / s_payload   in         rpn_in_t  (func, push_value)
// result    m_valid / m_ready / m_payload   out        rpn_out_t (status, depth, top_value)
//
// Each item passes the back end's idle, decode and finish states; multiply, divide
// and remainder wait between on the arith unit (one-bit-per-cycle shared divider).
// Front register and a two-entry queue keep taking items while the back end works, until they fill.
// aresetn is synchronous, active low; the stack memory is not cleared, depth goes to 0.
// A stalled result holds in the output register; the back end waits to commit.
module rpn_stack_calculator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpn_pkg::rpn_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output rpn_pkg::rpn_out_t m_payload
);
    import rpn_pkg::*;

    logic     f_valid;
    logic     f_ready;
    rpn_cmd_t f_cmd;
    logic     b_valid;
    logic     b_ready;
    rpn_cmd_t b_cmd;

    rpn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_cmd     (f_cmd)
    );

    rpn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    rpn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_cmd     (b_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );
endmodule
